FILE: hw/rtl/fpp_pkg.sv
package fpp_pkg;

    localparam logic [31:0] DEFAULT_FRAME_US = 32'd16742;

    // item kinds carried on s_tuser; codes 6 and 7 are no-ops
    localparam logic [2:0] KIND_START     = 3'd0;
    localparam logic [2:0] KIND_TICK      = 3'd1;
    localparam logic [2:0] KIND_PRESENTED = 3'd2;
    localparam logic [2:0] KIND_SET_PER   = 3'd3;
    localparam logic [2:0] KIND_DELAY     = 3'd4;
    localparam logic [2:0] KIND_REBASE    = 3'd5;

    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 136;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] now_us;
        logic [31:0] new_frame_period;
        logic [31:0] settle_time;
    } item_t;

    typedef struct packed {
        logic        present;
        logic [63:0] delay_us;
        logic [31:0] held_count;
        logic [31:0] last_settle;
    } result_t;

    // handshake between the core and the period multiplier
    typedef struct packed {
        logic start;
        logic clear;
    } mul_ctl_t;

    typedef struct packed {
        logic busy;
        logic rdy;
    } mul_sts_t;

endpackage

FILE: hw/rtl/fpp_mul.sv
// frame_count * period, low 64 bits, two registered stages
module fpp_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  fpp_pkg::mul_ctl_t   ctl,
    input  logic [63:0]         a,
    input  logic [31:0]         b,
    output fpp_pkg::mul_sts_t   sts,
    output logic [63:0]         prod
);

    logic        v1_reg;
    logic        rdy_reg;
    logic [63:0] p_lo_reg;
    logic [31:0] p_hi_reg;
    logic [63:0] prod_reg;
    logic [63:0] p_lo_next;
    logic [31:0] p_hi_next;

    assign p_lo_next = {32'd0, a[31:0]} * {32'd0, b};
    assign p_hi_next = a[63:32] * b;   // only the low half survives the shift

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            rdy_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.start;
            if (v1_reg)
                rdy_reg <= 1'b1;
            else if (ctl.clear)
                rdy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            p_lo_reg <= p_lo_next;
            p_hi_reg <= p_hi_next;
        end
        if (v1_reg)
            prod_reg <= p_lo_reg + {p_hi_reg, 32'd0};
    end

    assign sts.busy = v1_reg | rdy_reg;
    assign sts.rdy  = rdy_reg;
    assign prod     = prod_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |-> !v1_reg && !rdy_reg)
        else $error("multiply started while busy");
    a_rdy_follows: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |=> rdy_reg)
        else $error("product not flagged ready");
    a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rdy_reg && !v1_reg && $past(rdy_reg) |-> $stable(prod_reg))
        else $error("product changed while waiting");
`endif

endmodule

FILE: hw/rtl/fpp_core.sv
// pacer state and the per-item decision
module fpp_core (
    input  logic                clk,
    input  logic                rst_n,
    input  fpp_pkg::item_t      item,
    input  logic                item_vld,
    input  logic                advance,
    input  logic [15:0]         divisor,
    output logic                done,
    output fpp_pkg::result_t    result
);

    logic [63:0] start_reg,   start_next;
    logic [63:0] fc_reg,      fc_next;
    logic [31:0] period_reg,  period_next;
    logic [63:0] elapsed_reg, elapsed_next;   // fc_reg * period_reg, wrapped
    logic [63:0] hold_reg,    hold_next;
    logic [31:0] settle_reg,  settle_next;
    logic [31:0] held_reg,    held_next;
    logic [63:0] npf_reg,     npf_next;

    logic [31:0] fu;
    logic        setp_chg;
    logic        hold_active;
    logic        show;
    logic [63:0] due;
    logic [63:0] div_eff;
    logic [63:0] rb_elapsed;
    logic [63:0] rb_start;
    logic [63:0] delay;

    fpp_pkg::mul_ctl_t mul_ctl;
    fpp_pkg::mul_sts_t mul_sts;
    logic [63:0]       mul_prod;

    fpp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .a     (fc_reg),
        .b     (fu),
        .sts   (mul_sts),
        .prod  (mul_prod)
    );

    always_comb
    begin
        fu          = (item.new_frame_period != 32'd0) ? item.new_frame_period
                                                       : fpp_pkg::DEFAULT_FRAME_US;
        setp_chg    = (item.kind == fpp_pkg::KIND_SET_PER) && (fu != period_reg);
        hold_active = (hold_reg != 64'd0) && (item.now_us < hold_reg);
        show        = (fc_reg >= npf_reg) && !hold_active;
        due         = start_reg + elapsed_reg;
        div_eff     = (divisor != 16'd0) ? {48'd0, divisor} : 64'd1;
        rb_elapsed  = (item.kind == fpp_pkg::KIND_SET_PER) ? mul_prod : elapsed_reg;
        rb_start    = (item.now_us >= rb_elapsed) ? item.now_us - rb_elapsed : 64'd0;
        delay       = 64'd0;

        start_next   = start_reg;
        fc_next      = fc_reg;
        period_next  = period_reg;
        elapsed_next = elapsed_reg;
        hold_next    = hold_reg;
        settle_next  = settle_reg;
        held_next    = held_reg;
        npf_next     = npf_reg;

        case (item.kind)
            fpp_pkg::KIND_START:
            begin
                start_next   = item.now_us;
                fc_next      = 64'd0;
                period_next  = fu;
                elapsed_next = 64'd0;
                hold_next    = 64'd0;
                settle_next  = 32'd0;
                held_next    = 32'd0;
                npf_next     = 64'd0;
            end
            fpp_pkg::KIND_TICK:
            begin
                if ((fc_reg >= npf_reg) && hold_active)
                    held_next = held_reg + 32'd1;
                if (show)
                    npf_next = fc_reg + div_eff;
                fc_next      = fc_reg + 64'd1;
                elapsed_next = elapsed_reg + {32'd0, period_reg};
            end
            fpp_pkg::KIND_PRESENTED:
            begin
                settle_next = item.settle_time;
                // a sum that wraps to zero reads as no hold, same as zero settle
                hold_next   = (item.settle_time != 32'd0)
                              ? item.now_us + {32'd0, item.settle_time} : 64'd0;
            end
            fpp_pkg::KIND_SET_PER:
            begin
                if (setp_chg)
                begin
                    period_next  = fu;
                    elapsed_next = mul_prod;
                    start_next   = rb_start;
                end
            end
            fpp_pkg::KIND_DELAY:
            begin
                delay = (item.now_us >= due) ? 64'd0 : due - item.now_us;
            end
            fpp_pkg::KIND_REBASE:
            begin
                start_next = rb_start;
            end
            default:
            begin
            end
        endcase

        result.present     = (item.kind == fpp_pkg::KIND_TICK) && show;
        result.delay_us    = delay;
        result.held_count  = held_next;
        result.last_settle = settle_next;

        done          = item_vld && (!setp_chg || mul_sts.rdy);
        mul_ctl.start = item_vld && setp_chg && !mul_sts.busy;
        mul_ctl.clear = advance;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= 64'd0;
            fc_reg      <= 64'd0;
            period_reg  <= fpp_pkg::DEFAULT_FRAME_US;
            elapsed_reg <= 64'd0;
            hold_reg    <= 64'd0;
            settle_reg  <= 32'd0;
            held_reg    <= 32'd0;
            npf_reg     <= 64'd0;
        end
        else if (advance)
        begin
            start_reg   <= start_next;
            fc_reg      <= fc_next;
            period_reg  <= period_next;
            elapsed_reg <= elapsed_next;
            hold_reg    <= hold_next;
            settle_reg  <= settle_next;
            held_reg    <= held_next;
            npf_reg     <= npf_next;
        end
    end

`ifndef SYNTHESIS
    a_adv_done: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> done)
        else $error("item retired before done");
    a_setp_prod: assert property (@(posedge clk) disable iff (!rst_n)
        advance && setp_chg |-> mul_sts.rdy)
        else $error("period change retired without product");
    a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.kind == fpp_pkg::KIND_TICK |=> fc_reg == $past(fc_reg) + 64'd1)
        else $error("tick did not advance frame count");
    a_elapsed_tick: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.kind == fpp_pkg::KIND_TICK
        |=> elapsed_reg == $past(elapsed_reg) + {32'd0, $past(period_reg)})
        else $error("elapsed time out of step with tick");
`endif

endmodule

FILE: hw/rtl/frame_present_pacer.sv
// Channel   Dir  Payload                                           Accepted when
// s_*       in   tuser: kind; tdata: now_us, new_frame_period,     s_tvalid & s_tready
//                settle_time
// m_*       out  tdata: present, delay_us, held_count, last_settle m_tvalid & m_tready
// cfg_*     in   divisor                                           cfg_we
//
// One request per cycle is taken unless the input stalls; a request retires once the
// core is done and the output slot is open. A set-period request that changes the
// period holds the input while the two-stage frame_count * period multiplier runs.
// The output register frees the input side: a new request is taken while a result
// waits on m_tready; the input stalls while it holds a request that cannot yet retire.
// Reset clears the pacer state, sets the period to the default and the divisor to 1.
module frame_present_pacer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [2:0]                      s_tuser,   // kind
    // now_us[63:0], new_frame_period[95:64], settle_time[127:96]
    input  logic [fpp_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // present[0], delay_us[64:1], held_count[96:65], last_settle[128:97], zero pad
    output logic [fpp_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_we,
    input  logic [15:0]                     cfg_wdata
);

    logic               in_vld_reg;
    fpp_pkg::item_t     in_item_reg;
    logic               out_vld_reg;
    fpp_pkg::result_t   out_res_reg;
    logic [15:0]        div_reg;

    logic               core_done;
    fpp_pkg::result_t   core_res;
    logic               out_free;
    logic               advance;
    logic               s_acc;

    // a request retires when the core has its answer and the output slot is open
    assign out_free = !out_vld_reg || m_tready;
    assign advance  = in_vld_reg && core_done && out_free;
    assign s_tready = !in_vld_reg || advance;
    assign s_acc    = s_tvalid && s_tready;

    fpp_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (in_item_reg),
        .item_vld (in_vld_reg),
        .advance  (advance),
        .divisor  (div_reg),
        .done     (core_done),
        .result   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            div_reg     <= 16'd1;
        end
        else
        begin
            if (s_acc)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;

            if (advance)
                out_vld_reg <= 1'b1;
            else if (m_tready)
                out_vld_reg <= 1'b0;

            if (cfg_we)
                div_reg <= cfg_wdata;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            in_item_reg.kind             <= s_tuser;
            in_item_reg.now_us           <= s_tdata[63:0];
            in_item_reg.new_frame_period <= s_tdata[95:64];
            in_item_reg.settle_time      <= s_tdata[127:96];
        end
        if (advance)
            out_res_reg <= core_res;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_res_reg.last_settle, out_res_reg.held_count,
                       out_res_reg.delay_us, out_res_reg.present};

`ifndef SYNTHESIS
    a_adv_slot: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> !out_vld_reg || m_tready)
        else $error("result overwrote a pending output");
    a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("retired request produced no output");
    a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !advance |=> in_vld_reg && $stable(in_item_reg))
        else $error("pending request lost");
`endif

endmodule
